// ----- src/pce_pkg.sv -----
// Shared types and constants for the palette color encoder register port.
package pce_pkg;

    localparam int PALETTE_DEPTH_DEF = 512;

    localparam int ACTION_W = 2;
    localparam int REG_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int DIV_W    = 3;
    localparam int LINES_W  = 9;
    localparam int COLOR_W  = 9;
    localparam int PIXOUT_W = 16;
    localparam int MONO_BIT = 15;

    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PIXEL = 2'd2;

    localparam logic [REG_W-1:0] REG_CTRL    = 3'd0;
    localparam logic [REG_W-1:0] REG_ADDR_LO = 3'd2;
    localparam logic [REG_W-1:0] REG_ADDR_HI = 3'd3;
    localparam logic [REG_W-1:0] REG_DATA_LO = 3'd4;
    localparam logic [REG_W-1:0] REG_DATA_HI = 3'd5;

    localparam logic [DIV_W-1:0]   DIV_FOUR    = 3'd4;
    localparam logic [DIV_W-1:0]   DIV_THREE   = 3'd3;
    localparam logic [DIV_W-1:0]   DIV_TWO     = 3'd2;
    localparam logic [LINES_W-1:0] LINES_SHORT = 9'd262;
    localparam logic [LINES_W-1:0] LINES_LONG  = 9'd263;

    localparam logic [COLOR_W-1:0] BLANK_COLOR = 9'h1FF;
    localparam logic [BYTE_W-1:0]  RD_UNMAPPED = 8'hFF;
    localparam logic [BYTE_W-1:0]  RD_HI_BASE  = 8'hFE;

    typedef enum logic [2:0] {
        K_NONE,
        K_RD_LO,
        K_RD_HI,
        K_RD_FF,
        K_PIXEL
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               blank;
        logic               mono;
        logic [DIV_W-1:0]   div;
        logic [LINES_W-1:0] lines;
    } t_s1;

endpackage

// ----- src/palette_color_encoder_regs.sv -----
// Palette color encoder register port: top level.
// A result passes the stage-one register (with the palette RAM read data), then the output register.
// One item per cycle while o_stall is low; the palette RAM read port is used once per item.
// Reset (synchronous, active low) sets divider 4, 262 lines, color mode, address 0.
// After reset a sweep zeroes every palette entry; o_stall stays high meanwhile.
module palette_color_encoder_regs import pce_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [ACTION_W-1:0]              i_action,
    input  logic [REG_W-1:0]                 i_reg_addr,
    input  logic [BYTE_W-1:0]                i_write_data,
    input  logic [$clog2(PALETTE_DEPTH)-1:0] i_pixel_index,
    input  logic                             i_pixel_blank,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [BYTE_W-1:0]                o_read_data,
    output logic [PIXOUT_W-1:0]              o_pixel_color,
    output logic [DIV_W-1:0]                 o_dot_divider,
    output logic [LINES_W-1:0]               o_frame_lines
);

    t_s1               s1;
    logic              s1_vld;
    logic              take;
    logic [BYTE_W-1:0] ram_lo;
    logic              ram_hi;

    pce_front #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_reg_addr    (i_reg_addr),
        .i_write_data  (i_write_data),
        .i_pixel_index (i_pixel_index),
        .i_pixel_blank (i_pixel_blank),
        .i_take        (take),
        .o_s1          (s1),
        .o_s1_vld      (s1_vld),
        .o_ram_lo      (ram_lo),
        .o_ram_hi      (ram_hi)
    );

    pce_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s1          (s1),
        .i_s1_vld      (s1_vld),
        .i_ram_lo      (ram_lo),
        .i_ram_hi      (ram_hi),
        .o_take        (take),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_data   (o_read_data),
        .o_pixel_color (o_pixel_color),
        .o_dot_divider (o_dot_divider),
        .o_frame_lines (o_frame_lines)
    );

endmodule

// ----- src/pce_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/pce_front.sv -----
// Input decode: control registers, palette address, palette RAMs and clear sweep.
module pce_front import pce_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [ACTION_W-1:0]              i_action,
    input  logic [REG_W-1:0]                 i_reg_addr,
    input  logic [BYTE_W-1:0]                i_write_data,
    input  logic [$clog2(PALETTE_DEPTH)-1:0] i_pixel_index,
    input  logic                             i_pixel_blank,
    input  logic                             i_take,
    output t_s1                              o_s1,
    output logic                             o_s1_vld,
    output logic [BYTE_W-1:0]                o_ram_lo,
    output logic                             o_ram_hi
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(PALETTE_DEPTH - 1);

    logic [AW-1:0]      r_addr, n_addr;
    logic [DIV_W-1:0]   r_div, n_div;
    logic [LINES_W-1:0] r_lines, n_lines;
    logic               r_mono, n_mono;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_cnt;
    t_s1                r_s1, n_s1;
    logic               r_s1_vld;

    logic          accept;
    logic          is_wr, is_rd;
    logic          we_lo, we_hi;
    logic [AW-1:0] waddr, raddr;
    logic [BYTE_W-1:0] wdata_lo;
    logic          wdata_hi;

    assign o_stall = r_clr_busy || (r_s1_vld && !i_take);
    assign accept  = i_valid && !o_stall;
    assign is_wr   = accept && (i_action == ACT_WRITE);
    assign is_rd   = accept && (i_action == ACT_READ);

    // Register file and address update for the transfer in this cycle
    always_comb begin
        n_addr  = r_addr;
        n_div   = r_div;
        n_lines = r_lines;
        n_mono  = r_mono;
        if (is_wr) begin
            unique case (i_reg_addr)
                REG_CTRL: begin
                    unique case (i_write_data[1:0])
                        2'd0:    n_div = DIV_FOUR;
                        2'd1:    n_div = DIV_THREE;
                        default: n_div = DIV_TWO;
                    endcase
                    n_lines = i_write_data[2] ? LINES_LONG : LINES_SHORT;
                    n_mono  = i_write_data[BYTE_W-1];
                end
                REG_ADDR_LO: n_addr[AW-2:0] = i_write_data[AW-2:0];
                REG_ADDR_HI: n_addr[AW-1]   = i_write_data[0];
                REG_DATA_HI: n_addr         = r_addr + AW'(1);
                default:     n_addr         = r_addr;
            endcase
        end else if (is_rd && (i_reg_addr == REG_DATA_HI)) begin
            n_addr = r_addr + AW'(1);
        end
    end

    always_comb begin
        n_s1.blank = i_pixel_blank;
        n_s1.mono  = n_mono;
        n_s1.div   = n_div;
        n_s1.lines = n_lines;
        unique case (i_action)
            ACT_READ: begin
                if (i_reg_addr == REG_DATA_LO) begin
                    n_s1.kind = K_RD_LO;
                end else if (i_reg_addr == REG_DATA_HI) begin
                    n_s1.kind = K_RD_HI;
                end else begin
                    n_s1.kind = K_RD_FF;
                end
            end
            ACT_PIXEL: n_s1.kind = K_PIXEL;
            default:   n_s1.kind = K_NONE;
        endcase
    end

    // Palette ports: the clear sweep owns the write side after reset
    assign we_lo    = r_clr_busy || (is_wr && (i_reg_addr == REG_DATA_LO));
    assign we_hi    = r_clr_busy || (is_wr && (i_reg_addr == REG_DATA_HI));
    assign waddr    = r_clr_busy ? r_clr_cnt : r_addr;
    assign wdata_lo = r_clr_busy ? '0 : i_write_data;
    assign wdata_hi = r_clr_busy ? 1'b0 : i_write_data[0];
    assign raddr    = (i_action == ACT_PIXEL) ? i_pixel_index : r_addr;

    pce_ram #(.WIDTH(BYTE_W), .DEPTH(PALETTE_DEPTH)) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (we_lo),
        .i_waddr (waddr),
        .i_wdata (wdata_lo),
        .i_re    (accept),
        .i_raddr (raddr),
        .o_rdata (o_ram_lo)
    );

    pce_ram #(.WIDTH(1), .DEPTH(PALETTE_DEPTH)) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (we_hi),
        .i_waddr (waddr),
        .i_wdata (wdata_hi),
        .i_re    (accept),
        .i_raddr (raddr),
        .o_rdata (o_ram_hi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_div      <= DIV_FOUR;
            r_lines    <= LINES_SHORT;
            r_mono     <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
            r_s1_vld   <= 1'b0;
        end else begin
            r_addr  <= n_addr;
            r_div   <= n_div;
            r_lines <= n_lines;
            r_mono  <= n_mono;
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
                if (r_clr_cnt == ADDR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (i_take) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1     = r_s1;
    assign o_s1_vld = r_s1_vld;

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> o_stall)
        else $error("transfer possible during palette clear");

    a_addr_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_reg_addr == REG_DATA_HI &&
         (i_action == ACT_WRITE || i_action == ACT_READ))
        |=> r_addr == $past(r_addr) + AW'(1))
        else $error("palette address did not advance on data high access");

    a_div_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div == DIV_TWO || r_div == DIV_THREE || r_div == DIV_FOUR)
        else $error("dot divider out of range");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !i_take) |=> r_s1_vld && $stable(r_s1))
        else $error("stage one lost an item while output was full");

endmodule

// ----- src/pce_back.sv -----
// Result formatting and output register.
module pce_back import pce_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_s1                  i_s1,
    input  logic                 i_s1_vld,
    input  logic [BYTE_W-1:0]    i_ram_lo,
    input  logic                 i_ram_hi,
    output logic                 o_take,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BYTE_W-1:0]    o_read_data,
    output logic [PIXOUT_W-1:0]  o_pixel_color,
    output logic [DIV_W-1:0]     o_dot_divider,
    output logic [LINES_W-1:0]   o_frame_lines
);

    logic                r_vld;
    logic [BYTE_W-1:0]   r_rd, n_rd;
    logic [PIXOUT_W-1:0] r_pc, n_pc;
    logic [DIV_W-1:0]    r_div;
    logic [LINES_W-1:0]  r_lines;
    logic [COLOR_W-1:0]  color;

    assign o_take = !r_vld || !i_stall;
    assign color  = i_s1.blank ? BLANK_COLOR : {i_ram_hi, i_ram_lo};

    always_comb begin
        n_rd = '0;
        n_pc = '0;
        unique case (i_s1.kind)
            K_RD_LO: n_rd = i_ram_lo;
            K_RD_HI: n_rd = RD_HI_BASE | BYTE_W'(i_ram_hi);
            K_RD_FF: n_rd = RD_UNMAPPED;
            K_PIXEL: begin
                n_pc           = PIXOUT_W'(color);
                n_pc[MONO_BIT] = i_s1.mono;
            end
            default: n_rd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_take) begin
            r_vld <= i_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_s1_vld) begin
            r_rd    <= n_rd;
            r_pc    <= n_pc;
            r_div   <= i_s1.div;
            r_lines <= i_s1.lines;
        end
    end

    assign o_valid       = r_vld;
    assign o_read_data   = r_rd;
    assign o_pixel_color = r_pc;
    assign o_dot_divider = r_div;
    assign o_frame_lines = r_lines;

    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_rd != '0) |-> r_pc == '0)
        else $error("read byte and pixel color both set");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the palette color encoder register port.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pce_pkg::*;

    localparam int IDX_W      = $clog2(PALETTE_DEPTH_DEF);
    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_ITEMS = 450;
    localparam int HOLD_LEN   = 64;

    // Codes the package leaves unnamed
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [REG_W-1:0]    REG_GAP1   = 3'd1;
    localparam logic [REG_W-1:0]    REG_GAP6   = 3'd6;
    localparam logic [REG_W-1:0]    REG_GAP7   = 3'd7;
    localparam logic [1:0] DCODE_FOUR  = 2'd0;
    localparam logic [1:0] DCODE_THREE = 2'd1;
    localparam logic [1:0] DCODE_TWO   = 2'd2;
    localparam logic [1:0] DCODE_BAD   = 2'd3;
    localparam int CTRL_LONG_BIT = 2;
    localparam int CTRL_MONO_BIT = 7;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [REG_W-1:0]    reg_addr;
        logic [BYTE_W-1:0]   wdata;
        logic [IDX_W-1:0]    idx;
        logic                blank;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    typedef struct packed {
        logic [BYTE_W-1:0]   rd;
        logic [PIXOUT_W-1:0] color;
        logic [DIV_W-1:0]    div;
        logic [LINES_W-1:0]  lines;
    } t_result;

    typedef struct {
        t_item   it;
        bit      fix_on;
        t_result fix;
    } t_row;

    localparam t_result NOFIX = '0;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [ACTION_W-1:0]   i_action;
    logic [REG_W-1:0]      i_reg_addr;
    logic [BYTE_W-1:0]     i_write_data;
    logic [IDX_W-1:0]      i_pixel_index;
    logic                  i_pixel_blank;
    logic                  o_valid;
    logic                  i_stall;
    logic [BYTE_W-1:0]     o_read_data;
    logic [PIXOUT_W-1:0]   o_pixel_color;
    logic [DIV_W-1:0]      o_dot_divider;
    logic [LINES_W-1:0]    o_frame_lines;

    // Typed expectation travels with the payload of a directed row
    bit      cur_fix_on;
    t_result cur_fix;

    // Predictor state
    logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH_DEF];
    logic [IDX_W-1:0]   pal_addr = '0;
    logic [DIV_W-1:0]   div_q    = DIV_FOUR;
    logic [LINES_W-1:0] lines_q  = LINES_SHORT;
    logic               mono_q   = 1'b0;

    t_result          pending_results[$];
    t_row             dir_tab[$];
    int               errors      = 0;
    int               offered     = 0;
    int               idle_cycles = 0;
    bit               tx_calm     = 1'b0;
    bit               hold_req    = 1'b0;
    logic [IDX_W-1:0] last_base   = '0;

    palette_color_encoder_regs dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_reg_addr    (i_reg_addr),
        .i_write_data  (i_write_data),
        .i_pixel_index (i_pixel_index),
        .i_pixel_blank (i_pixel_blank),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_data   (o_read_data),
        .o_pixel_color (o_pixel_color),
        .o_dot_divider (o_dot_divider),
        .o_frame_lines (o_frame_lines)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        foreach (pal_mem[i]) pal_mem[i] = '0;
    end

    // Apply one transfer to the predicted state and return the expected result
    function automatic t_result encoder_step(input t_item it);
        t_result          r;
        logic [IDX_W-1:0] a;
        r = '0;
        a = pal_addr;
        case (it.action)
            ACT_WRITE: begin
                case (it.reg_addr)
                    REG_CTRL: begin
                        case (it.wdata[1:0])
                            DCODE_FOUR:           div_q = DIV_FOUR;
                            DCODE_THREE:          div_q = DIV_THREE;
                            DCODE_TWO, DCODE_BAD: div_q = DIV_TWO;
                        endcase
                        lines_q = it.wdata[CTRL_LONG_BIT] ? LINES_LONG : LINES_SHORT;
                        mono_q  = it.wdata[CTRL_MONO_BIT];
                    end
                    REG_ADDR_LO: pal_addr[7:0] = it.wdata;
                    REG_ADDR_HI: pal_addr[8]   = it.wdata[0];
                    REG_DATA_LO: pal_mem[a][7:0] = it.wdata;
                    REG_DATA_HI: begin
                        pal_mem[a][8] = it.wdata[0];
                        pal_addr      = pal_addr + 1'b1;
                    end
                    default: ;
                endcase
            end
            ACT_READ: begin
                case (it.reg_addr)
                    REG_DATA_LO: r.rd = pal_mem[a][7:0];
                    REG_DATA_HI: begin
                        r.rd     = RD_HI_BASE | BYTE_W'(pal_mem[a][8]);
                        pal_addr = pal_addr + 1'b1;
                    end
                    default: r.rd = RD_UNMAPPED;
                endcase
            end
            ACT_PIXEL: begin
                r.color[COLOR_W-1:0] = it.blank ? BLANK_COLOR : pal_mem[it.idx];
                r.color[MONO_BIT]    = mono_q;
            end
            default: ;
        endcase
        r.div   = div_q;
        r.lines = lines_q;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
        end
    endfunction

    // Predict on every input transfer, compare on every output transfer
    always @(posedge i_clk) begin : scoreboard
        t_item   seen;
        t_result want;
        t_result got;
        if (i_rst_n && i_valid && o_stall === 1'b0) begin
            seen = '{i_action, i_reg_addr, i_write_data, i_pixel_index, i_pixel_blank};
            want = encoder_step(seen);
            if (cur_fix_on) want = cur_fix;
            pending_results.push_back(want);
        end
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            got = '{o_read_data, o_pixel_color, o_dot_divider, o_frame_lines};
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: rd 0x%0h color 0x%0h div %0d lines %0d",
                         $time, got.rd, got.color, got.div, got.lines);
            end else begin
                want = pending_results.pop_front();
                check_field("read_data", 16'(want.rd), 16'(got.rd));
                check_field("pixel_color", want.color, got.color);
                check_field("dot_divider", 16'(want.div), 16'(got.div));
                check_field("frame_lines", 16'(want.lines), 16'(got.lines));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stall per transfer, calm stretches, one long hold-off
    initial begin : receiver
        int n;
        int calm;
        calm = 0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                n = HOLD_LEN;
            end else if (calm > 0) begin
                calm--;
                n = 0;
            end else begin
                n = $urandom_range(0, 3);
                if ($urandom_range(0, 19) == 0) calm = 25;
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    task automatic offer(input t_item it, input bit fix_on, input t_result fix);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= it.action;
        i_reg_addr    <= it.reg_addr;
        i_write_data  <= it.wdata;
        i_pixel_index <= it.idx;
        i_pixel_blank <= it.blank;
        cur_fix_on    <= fix_on;
        cur_fix       <= fix;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        offered++;
    endtask

    // Bus access with random content in the fields it does not use
    task automatic offer_bus(input logic [ACTION_W-1:0] act, input logic [REG_W-1:0] ra,
                             input logic [BYTE_W-1:0] wd);
        t_item it;
        it          = ITEM_W'($urandom);
        it.action   = act;
        it.reg_addr = ra;
        it.wdata    = wd;
        offer(it, 1'b0, NOFIX);
    endtask

    task automatic offer_pix(input logic [IDX_W-1:0] idx, input logic blank);
        t_item it;
        it        = ITEM_W'($urandom);
        it.action = ACT_PIXEL;
        it.idx    = idx;
        it.blank  = blank;
        offer(it, 1'b0, NOFIX);
    endtask

    task automatic set_address(input logic [IDX_W-1:0] base);
        offer_bus(ACT_WRITE, REG_ADDR_LO, base[7:0]);
        offer_bus(ACT_WRITE, REG_ADDR_HI, {7'($urandom), base[8]});
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Bases near the top of the palette exercise address wrap
    function automatic logic [IDX_W-1:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return IDX_W'($urandom_range(0, 15));
            1:       return IDX_W'($urandom_range(500, 511));
            2:       return IDX_W'($urandom);
            default: return last_base;
        endcase
    endfunction

    function automatic t_row row(input logic [ACTION_W-1:0] act, input logic [REG_W-1:0] ra,
                                 input logic [BYTE_W-1:0] wd, input logic [IDX_W-1:0] idx,
                                 input logic blank, input bit fix_on, input t_result fix);
        t_row r;
        r.it     = '{act, ra, wd, idx, blank};
        r.fix_on = fix_on;
        r.fix    = fix;
        return r;
    endfunction

    initial begin : stimulus
        int               goal;
        int               n;
        int               k;
        bit               hold_done;
        bit               pause_done;
        t_item            it;
        logic [IDX_W-1:0] base;

        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_action      <= '0;
        i_reg_addr    <= '0;
        i_write_data  <= '0;
        i_pixel_index <= '0;
        i_pixel_blank <= 1'b0;
        cur_fix_on    <= 1'b0;
        cur_fix       <= NOFIX;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        // State right after reset: divider 4, 262 lines, color mode, address 0, palette zero
        dir_tab.push_back(row(ACT_PIXEL, REG_CTRL, 8'h00, 9'd0, 1'b0,
                              1'b1, '{8'h00, 16'h0000, DIV_FOUR, LINES_SHORT}));
        dir_tab.push_back(row(ACT_PIXEL, REG_GAP7, 8'hFF, 9'd511, 1'b1,
                              1'b1, '{8'h00, 16'h01FF, DIV_FOUR, LINES_SHORT}));
        // Unmapped read offsets
        dir_tab.push_back(row(ACT_READ, REG_CTRL, 8'hFF, 9'd511, 1'b1,
                              1'b1, '{RD_UNMAPPED, 16'h0000, DIV_FOUR, LINES_SHORT}));
        dir_tab.push_back(row(ACT_READ, REG_GAP1, 8'h00, 9'd0, 1'b0,
                              1'b1, '{RD_UNMAPPED, 16'h0000, DIV_FOUR, LINES_SHORT}));
        dir_tab.push_back(row(ACT_READ, REG_ADDR_LO, 8'hFF, 9'd511, 1'b1,
                              1'b1, '{RD_UNMAPPED, 16'h0000, DIV_FOUR, LINES_SHORT}));
        dir_tab.push_back(row(ACT_READ, REG_ADDR_HI, 8'h00, 9'd0, 1'b0,
                              1'b1, '{RD_UNMAPPED, 16'h0000, DIV_FOUR, LINES_SHORT}));
        dir_tab.push_back(row(ACT_READ, REG_GAP6, 8'hFF, 9'd511, 1'b1,
                              1'b1, '{RD_UNMAPPED, 16'h0000, DIV_FOUR, LINES_SHORT}));
        // Cleared entry 0, then the high read advances the address
        dir_tab.push_back(row(ACT_READ, REG_DATA_LO, 8'h00, 9'd0, 1'b0,
                              1'b1, '{8'h00, 16'h0000, DIV_FOUR, LINES_SHORT}));
        dir_tab.push_back(row(ACT_READ, REG_DATA_HI, 8'hFF, 9'd511, 1'b1,
                              1'b1, '{RD_HI_BASE, 16'h0000, DIV_FOUR, LINES_SHORT}));
        // Illegal divider code, long frame, mono on
        dir_tab.push_back(row(ACT_WRITE, REG_CTRL, 8'h87, 9'd0, 1'b0,
                              1'b1, '{8'h00, 16'h0000, DIV_TWO, LINES_LONG}));
        dir_tab.push_back(row(ACT_PIXEL, REG_GAP1, 8'h00, 9'd5, 1'b1,
                              1'b1, '{8'h00, 16'h81FF, DIV_TWO, LINES_LONG}));
        dir_tab.push_back(row(ACT_PIXEL, REG_GAP1, 8'hFF, 9'd0, 1'b0,
                              1'b1, '{8'h00, 16'h8000, DIV_TWO, LINES_LONG}));
        dir_tab.push_back(row(ACT_WRITE, REG_CTRL, 8'h01, 9'd511, 1'b1,
                              1'b1, '{8'h00, 16'h0000, DIV_THREE, LINES_SHORT}));
        dir_tab.push_back(row(ACT_WRITE, REG_CTRL, 8'h02, 9'd0, 1'b0,
                              1'b1, '{8'h00, 16'h0000, DIV_TWO, LINES_SHORT}));
        // Load the top entry; the high write wraps the address to zero
        dir_tab.push_back(row(ACT_WRITE, REG_ADDR_LO, 8'hFF, 9'd0, 1'b0, 1'b0, NOFIX));
        dir_tab.push_back(row(ACT_WRITE, REG_ADDR_HI, 8'h01, 9'd511, 1'b1, 1'b0, NOFIX));
        dir_tab.push_back(row(ACT_WRITE, REG_DATA_LO, 8'hAA, 9'd0, 1'b0, 1'b0, NOFIX));
        dir_tab.push_back(row(ACT_WRITE, REG_DATA_HI, 8'hFF, 9'd511, 1'b1, 1'b0, NOFIX));
        dir_tab.push_back(row(ACT_PIXEL, REG_DATA_HI, 8'h00, 9'd511, 1'b0, 1'b0, NOFIX));
        // Read it back across the wrap
        dir_tab.push_back(row(ACT_WRITE, REG_ADDR_LO, 8'hFF, 9'd0, 1'b0, 1'b0, NOFIX));
        dir_tab.push_back(row(ACT_WRITE, REG_ADDR_HI, 8'hFF, 9'd0, 1'b0, 1'b0, NOFIX));
        dir_tab.push_back(row(ACT_READ, REG_DATA_LO, 8'h00, 9'd0, 1'b0, 1'b0, NOFIX));
        dir_tab.push_back(row(ACT_READ, REG_DATA_HI, 8'h00, 9'd0, 1'b0, 1'b0, NOFIX));
        // Ignored write offsets and the unused action
        dir_tab.push_back(row(ACT_WRITE, REG_GAP1, 8'hFF, 9'd511, 1'b1, 1'b0, NOFIX));
        dir_tab.push_back(row(ACT_WRITE, REG_GAP7, 8'hFF, 9'd511, 1'b1, 1'b0, NOFIX));
        dir_tab.push_back(row(ACT_UNUSED, REG_DATA_HI, 8'hFF, 9'd511, 1'b1,
                              1'b1, '{8'h00, 16'h0000, DIV_TWO, LINES_SHORT}));
        dir_tab.push_back(row(ACT_WRITE, REG_CTRL, 8'hFF, 9'd511, 1'b1,
                              1'b1, '{8'h00, 16'h0000, DIV_TWO, LINES_LONG}));
        dir_tab.push_back(row(ACT_WRITE, REG_CTRL, 8'h00, 9'd0, 1'b0,
                              1'b1, '{8'h00, 16'h0000, DIV_FOUR, LINES_SHORT}));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) offer(dir_tab[i].it, dir_tab[i].fix_on, dir_tab[i].fix);

        goal = offered + RAND_ITEMS;
        while (offered < goal) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            if (!hold_done && offered >= goal - RAND_ITEMS + 150) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && offered >= goal - RAND_ITEMS + 300) begin
                drain_results();
                pause_done = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // Palette load; now and then the high address byte is left out
                    base      = pick_base();
                    last_base = base;
                    if ($urandom_range(0, 5) == 0)
                        offer_bus(ACT_WRITE, REG_ADDR_LO, base[7:0]);
                    else
                        set_address(base);
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        offer_bus(ACT_WRITE, REG_DATA_LO, 8'($urandom));
                        offer_bus(ACT_WRITE, REG_DATA_HI, 8'($urandom));
                    end
                end
                3, 4: begin
                    base = pick_base();
                    set_address(base);
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        k = $urandom_range(0, 5);
                        if (k != 0) offer_bus(ACT_READ, REG_DATA_LO, 8'($urandom));
                        if (k != 1) offer_bus(ACT_READ, REG_DATA_HI, 8'($urandom));
                    end
                end
                5, 6, 7: begin
                    // Mostly look up entries near the last load
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        if ($urandom_range(0, 3) != 0)
                            base = last_base + IDX_W'($urandom_range(0, 7));
                        else
                            base = IDX_W'($urandom);
                        offer_pix(base, $urandom_range(0, 7) == 0);
                    end
                end
                8: offer_bus(ACT_WRITE, REG_CTRL, 8'($urandom));
                default: begin
                    n = $urandom_range(1, 3);
                    repeat (n) begin
                        it = ITEM_W'($urandom);
                        offer(it, 1'b0, NOFIX);
                    end
                end
            endcase
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
src/pce_pkg.sv
src/pce_ram.sv
src/pce_front.sv
src/pce_back.sv
src/palette_color_encoder_regs.sv
verif/testbench.sv
